/* rtl/ulsc_pkg.sv */
// Shared constants, types and the element position table of the lateral scan converter.
package ulsc_pkg;

	// Frame geometry fixed by the probe
	localparam int LINES       = 128;
	localparam int LINE_W      = 7;
	localparam int TOTAL_UNITS = 6080;
	localparam int POS_W       = 13;
	localparam int STEP_W      = 7;

	// Default image and frame sizes
	localparam int SAMPLES_PER_LINE_DEF = 520;
	localparam int IMAGE_WIDTH_DEF      = 768;
	localparam int IMAGE_HEIGHT_DEF     = 701;

	typedef logic [POS_W-1:0] pos_t;
	typedef pos_t [LINES-1:0] pos_tab_t;

	// Item opcodes
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	// Pixel sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROWDIV,
		ST_RD0,
		ST_RD1,
		ST_MUL,
		ST_SUM,
		ST_PIXDIV,
		ST_DONE
	} state_t;

	// Element positions in units of 0.00625 mm: coarse at the edges, fine in the middle
	function automatic pos_tab_t build_elem_pos();
		pos_tab_t tab;
		int p;
		p = 0;
		for (int i = 0; i < LINES; i++) begin
			if (i == 0) begin
				p = 0;
			end else if (i < 16) begin
				p = p + 64;
			end else if (i < 48) begin
				p = p + 64 - (i - 15);
			end else if (i < 80) begin
				p = p + 32;
			end else if (i < 112) begin
				p = p + 32 + (i - 79);
			end else begin
				p = p + 64;
			end
			tab[i] = POS_W'(p);
		end
		return tab;
	endfunction

	localparam pos_tab_t ELEM_POS = build_elem_pos();

endpackage

/* rtl/ultrasound_lateral_scan_converter_unit.sv */
// Lateral scan converter: sample frame store, element search and linear interpolation.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per item. opcode OP_WRITE
//   stores sample_value at (line_index, sample_index) of the frame memory in the
//   accept cycle; writes with sample_index past the line length are dropped. A write
//   beat can follow every cycle while no pixel is in progress. opcode OP_PIXEL
//   requests the grey value of (pixel_column, pixel_row) and produces one beat on
//   the output channel (out_valid / out_stall).
//   A pixel goes through a row divide that runs alongside a 7-step binary search of
//   the element table, two frame memory reads, a multiply and a divide. The input
//   stalls until a pixel's result is loaded into the output register. A column past
//   the table skips the sum and the divide. The divider retires two quotient bits per
//   cycle in the row divide and in the pixel divide.
//   The output register holds one finished result; the next item is accepted while it
//   waits. When out_stall holds that register, a second pixel waits in its last state
//   and the input stalls.
//   Reset clears the sequencer and the output valid; the frame memory is not cleared
//   and a sample must be written before a pixel reads it.
module ultrasound_lateral_scan_converter_unit #(
	parameter int SAMPLES_PER_LINE = ulsc_pkg::SAMPLES_PER_LINE_DEF,
	parameter int IMAGE_WIDTH      = ulsc_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT     = ulsc_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [0:0] opcode,
	input  logic [6:0] line_index,
	input  logic [9:0] sample_index,
	input  logic [7:0] sample_value,
	input  logic [9:0] pixel_column,
	input  logic [9:0] pixel_row,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pixel_value
);

	localparam int LINES  = ulsc_pkg::LINES;
	localparam int LW     = ulsc_pkg::LINE_W;
	localparam int CS     = $clog2(SAMPLES_PER_LINE + 1);
	localparam int CH     = $clog2(IMAGE_HEIGHT + 1);
	localparam int CWD    = $clog2(IMAGE_WIDTH + 1);
	localparam int SW     = $clog2(SAMPLES_PER_LINE);
	localparam int DEPTH  = LINES * SAMPLES_PER_LINE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SCW    = (CS > 10) ? CS : 10;
	localparam int RSTEPS = (SW + 1) / 2;
	localparam int QRW    = 2 * RSTEPS;
	localparam int QW     = (QRW > 8) ? QRW : 8;
	localparam int ROW_CYC = (RSTEPS > LW) ? RSTEPS : LW;
	localparam int PSTEPS = 4;
	localparam int CNTW   = $clog2(ROW_CYC + 1);
	localparam int MAXB   = (CS > CH) ? CS : CH;
	localparam int RNW    = 12 + MAXB;
	localparam int RCW    = (RNW > 1 + CS + CH) ? RNW : 1 + CS + CH;
	localparam int LCW    = (13 + CWD > 23) ? 13 + CWD : 23;
	localparam int DW     = ulsc_pkg::STEP_W + CWD;
	localparam int NUMW   = DW + 8;
	localparam int PNW    = DW + 9;
	localparam int UW1    = (RNW > PNW) ? RNW : PNW;
	localparam int UW2    = (CH + QRW > DW + 8) ? CH + QRW : DW + 8;
	localparam int UW     = (UW1 > UW2) ? UW1 : UW2;

	localparam logic [UW-1:0]  ROW_DEN = UW'(2 * IMAGE_HEIGHT) << (QRW - 1);
	localparam logic [RCW-1:0] SAT_LIM = RCW'(2 * IMAGE_HEIGHT * SAMPLES_PER_LINE);

	ulsc_pkg::state_t state_q, state_d;
	logic             out_load;
	logic             in_accept;

	logic [7:0]        mem [DEPTH];
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic              mem_we;
	logic [7:0]        rd_q;

	logic [CNTW-1:0] cnt_q;
	logic [LCW-1:0]  loc_q;
	logic            found_q, sat_q;
	logic [LW-1:0]   idx_q, cand, line_a, idx_nx;
	logic [SW-1:0]   s_q, s_cur;
	logic [DW-1:0]   a_q, d_q;
	logic [7:0]      s0_q;
	logic [NUMW-1:0] p0_q, p1_q, num;
	logic [RCW-1:0]  rnum;
	logic [LCW-1:0]  lo_cand, lo_cur, hi_cur;

	logic [UW-1:0] rem_q, den_q, r1, r2, den1;
	logic          b1, b2, div_step, srch_step;
	logic [QW-1:0] quo_q;

	logic       out_valid_q;
	logic [7:0] pix_q;

	assign in_accept = in_valid && !in_stall;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ulsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			ulsc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && ulsc_pkg::op_t'(opcode) == ulsc_pkg::OP_PIXEL) begin
					state_d = ulsc_pkg::ST_ROWDIV;
				end
			end
			ulsc_pkg::ST_ROWDIV: begin
				if (cnt_q == CNTW'(ROW_CYC - 1)) begin
					state_d = ulsc_pkg::ST_RD0;
				end
			end
			ulsc_pkg::ST_RD0: state_d = ulsc_pkg::ST_RD1;
			ulsc_pkg::ST_RD1: state_d = ulsc_pkg::ST_MUL;
			ulsc_pkg::ST_MUL: begin
				state_d = found_q ? ulsc_pkg::ST_SUM : ulsc_pkg::ST_DONE;
			end
			ulsc_pkg::ST_SUM: state_d = ulsc_pkg::ST_PIXDIV;
			ulsc_pkg::ST_PIXDIV: begin
				if (cnt_q == CNTW'(PSTEPS - 1)) begin
					state_d = ulsc_pkg::ST_DONE;
				end
			end
			ulsc_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ulsc_pkg::ST_IDLE;
				end
			end
			default: state_d = ulsc_pkg::ST_IDLE;
		endcase
	end

	// Frame memory write and read addresses
	assign mem_we = in_accept && ulsc_pkg::op_t'(opcode) == ulsc_pkg::OP_WRITE
		&& SCW'(sample_index) < SCW'(SAMPLES_PER_LINE);
	assign mem_waddr = ADDR_W'(line_index) * ADDR_W'(SAMPLES_PER_LINE)
		+ ADDR_W'(sample_index);

	assign s_cur  = sat_q ? SW'(SAMPLES_PER_LINE - 1) : quo_q[SW-1:0];
	assign line_a = found_q ? idx_q : LW'(LINES - 2);
	assign idx_nx = idx_q + LW'(1);

	always_comb begin
		if (state_q == ulsc_pkg::ST_RD0) begin
			mem_raddr = ADDR_W'(line_a) * ADDR_W'(SAMPLES_PER_LINE) + ADDR_W'(s_cur);
		end else begin
			mem_raddr = ADDR_W'(idx_nx) * ADDR_W'(SAMPLES_PER_LINE) + ADDR_W'(s_q);
		end
	end

	// Frame memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= sample_value;
		end
		rd_q <= mem[mem_raddr];
	end

	// Shared restoring divider, two quotient bits per cycle
	assign b1   = rem_q >= den_q;
	assign r1   = b1 ? rem_q - den_q : rem_q;
	assign den1 = den_q >> 1;
	assign b2   = r1 >= den1;
	assign r2   = b2 ? r1 - den1 : r1;

	assign div_step = (state_q == ulsc_pkg::ST_ROWDIV && cnt_q < CNTW'(RSTEPS))
		|| state_q == ulsc_pkg::ST_PIXDIV;
	assign srch_step = state_q == ulsc_pkg::ST_ROWDIV && cnt_q < CNTW'(LW);

	// Binary search candidate: largest line whose position is at or left of the column
	assign cand    = idx_q | (LW'(1 << (LW - 1)) >> cnt_q);
	assign lo_cand = LCW'(ulsc_pkg::ELEM_POS[cand]) * LCW'(IMAGE_WIDTH);

	// Row numerator for the rounded depth index
	assign rnum = RCW'(pixel_row) * RCW'(2 * SAMPLES_PER_LINE) + RCW'(IMAGE_HEIGHT);

	// Interval bounds of the found line
	assign lo_cur = LCW'(ulsc_pkg::ELEM_POS[idx_q]) * LCW'(IMAGE_WIDTH);
	assign hi_cur = LCW'(ulsc_pkg::ELEM_POS[idx_nx]) * LCW'(IMAGE_WIDTH);

	assign num = p0_q + p1_q;

	// Control counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ulsc_pkg::ST_ROWDIV || state_q == ulsc_pkg::ST_PIXDIV) begin
			cnt_q <= cnt_q + CNTW'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// Pixel datapath
	always_ff @(posedge clk) begin
		if (in_accept) begin
			loc_q   <= LCW'(pixel_column) * LCW'(ulsc_pkg::TOTAL_UNITS);
			found_q <= LCW'(pixel_column) < LCW'(IMAGE_WIDTH);
			sat_q   <= rnum >= SAT_LIM;
			idx_q   <= '0;
			rem_q   <= UW'(rnum);
			den_q   <= ROW_DEN;
			quo_q   <= '0;
		end else if (state_q == ulsc_pkg::ST_SUM) begin
			rem_q <= UW'({num, 1'b0}) + UW'(d_q);
			den_q <= UW'(d_q) << 8;
			quo_q <= '0;
		end else if (div_step) begin
			rem_q <= r2;
			den_q <= den1 >> 1;
			quo_q <= {quo_q[QW-3:0], b1, b2};
		end
		if (srch_step && cand != LW'(LINES - 1) && lo_cand <= loc_q) begin
			idx_q <= cand;
		end
		if (state_q == ulsc_pkg::ST_RD0) begin
			s_q <= s_cur;
			a_q <= DW'(loc_q - lo_cur);
			d_q <= DW'(hi_cur - lo_cur);
		end
		if (state_q == ulsc_pkg::ST_RD1) begin
			s0_q <= rd_q;
		end
		if (state_q == ulsc_pkg::ST_MUL) begin
			p1_q <= NUMW'(a_q) * NUMW'(rd_q);
			p0_q <= NUMW'(d_q - a_q) * NUMW'(s0_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_q <= found_q ? quo_q[7:0] : s0_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pix_q;

`ifndef SYNTH
	a_pixel_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && ulsc_pkg::op_t'(opcode) == ulsc_pkg::OP_PIXEL)
		|=> state_q == ulsc_pkg::ST_ROWDIV)
		else $error("pixel beat did not start the row divide");

	a_search_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ulsc_pkg::ST_RD0 && found_q) |-> idx_q != LW'(LINES - 1))
		else $error("element search ran past the last interval");

	a_row_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ulsc_pkg::ST_RD0 && !sat_q)
		|-> (QW + 1)'(quo_q) < (QW + 1)'(SAMPLES_PER_LINE))
		else $error("depth index out of range without saturation");

	a_pixel_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ulsc_pkg::ST_DONE && found_q) |-> (quo_q >> 8) == '0)
		else $error("interpolated value exceeds 8 bits");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(pix_q) && out_valid_q)
		else $error("stalled result was overwritten");
`endif

endmodule
